// File: sv/led_pkg.sv
// Shared types and constants for the edit distance block.
// Depends on nothing; every other file uses it.
`timescale 1ns / 1ps

package led_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int DIST_W      = 6;
  localparam int CH_W        = 8;
  localparam int CMD_W       = 2;

  // command codes of the input beat
  typedef enum logic [CMD_W-1:0] {
    CMD_REF_APPEND  = 2'd0,
    CMD_CAND_APPEND = 2'd1,
    CMD_CAND_END    = 2'd2,
    CMD_REF_CLEAR   = 2'd3
  } cmd_t;

  // broadcast control from the head to every cell
  typedef struct packed {
    logic              restart;
    logic              ref_wr;
    logic [DIST_W-1:0] ref_len;
    logic [CH_W-1:0]   ref_ch;
  } cell_ctl_t;

  // wavefront token handed from one cell to the next
  typedef struct packed {
    logic              valid;
    logic [CH_W-1:0]   ch;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] diag;
  } tok_t;

endpackage

// File: sv/led_if.sv
// Valid/ready channel interfaces for the edit distance block.
// Depends on led_pkg for field widths.
`timescale 1ns / 1ps

interface led_req_if;
  logic                     valid;
  logic                     ready;
  logic [led_pkg::CMD_W-1:0] cmd;
  logic [led_pkg::CH_W-1:0]  ch;

  modport source (output valid, cmd, ch, input ready);
  modport sink   (input valid, cmd, ch, output ready);
endinterface

interface led_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [led_pkg::DIST_W-1:0] distance;
  logic                       overflow;

  modport source (output valid, distance, overflow, input ready);
  modport sink   (input valid, distance, overflow, output ready);
endinterface

// File: sv/led_cell.sv
// One cell of the systolic row: holds one reference character and one row entry.
// Depends on led_pkg for the control and token structs.
`timescale 1ns / 1ps

module led_cell #(
  parameter int IDX = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  led_pkg::cell_ctl_t         ctl,
  input  led_pkg::tok_t              tok_in,
  output led_pkg::tok_t              tok_out,
  output logic [led_pkg::DIST_W-1:0] dp
);
  import led_pkg::*;

  logic [CH_W-1:0]   ref_ch;
  logic              active;
  logic              is_match;
  logic [DIST_W:0]   up1, left1, diag0, min_m, min_x, v_wide;
  logic [DIST_W-1:0] v;
  logic              tok_valid;
  logic [CH_W-1:0]   tok_ch;
  logic [DIST_W-1:0] tok_left;
  logic [DIST_W-1:0] tok_diag;

  // cell takes part only while its reference position is loaded
  assign active   = DIST_W'(IDX) <= ctl.ref_len;
  assign is_match = ref_ch == tok_in.ch;

  // three-way minimum, on a wider word so that the increment cannot wrap early
  always_comb begin
    up1   = {1'b0, dp} + (DIST_W+1)'(1);
    left1 = {1'b0, tok_in.left} + (DIST_W+1)'(1);
    diag0 = {1'b0, tok_in.diag};
    min_m = (up1 < left1) ? up1 : left1;
    min_m = (min_m < diag0) ? min_m : diag0;
    min_x = (dp < tok_in.left) ? {1'b0, dp} : {1'b0, tok_in.left};
    min_x = (min_x < diag0) ? min_x : diag0;
    v_wide = is_match ? min_m : (min_x + (DIST_W+1)'(1));
    v      = v_wide[DIST_W-1:0];
  end

  // reference character store
  always_ff @(posedge clk) begin
    if (ctl.ref_wr && ctl.ref_len == DIST_W'(IDX - 1)) begin
      ref_ch <= ctl.ref_ch;
    end
  end

  // row entry and token valid
  always_ff @(posedge clk) begin
    if (rst) begin
      dp        <= DIST_W'(IDX);
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
      if (ctl.restart) begin
        dp <= DIST_W'(IDX);
      end else if (tok_in.valid && active) begin
        dp <= v;
      end
    end
  end

  // token payload to the next cell: new entry as left (the held entry when inactive), old entry as diagonal
  always_ff @(posedge clk) begin
    tok_ch   <= tok_in.ch;
    tok_left <= active ? v : dp;
    tok_diag <= dp;
  end

  assign tok_out = '{valid: tok_valid, ch: tok_ch, left: tok_left, diag: tok_diag};

endmodule

// File: sv/levenshtein_edit_distance.sv
// Top level of the edit distance block: command head, cell row and result register.
// Depends on led_pkg, led_if and led_cell.
//
//   channel  modport  beat                   role
//   req      sink     cmd, ch                commands and characters in
//   rsp      source   distance, overflow     one result per end command
//
// A candidate character is taken every cycle; its wave passes one cell per cycle.
// Reference append, end and clear wait until the last wave has left all MAX_LEN
// cells, so they stall while any wave is still inside the row.
// An end command also waits for the result register to be free.
// Reset is synchronous; afterwards the reference is empty and no wait is needed.
`timescale 1ns / 1ps

module levenshtein_edit_distance #(
  parameter int MAX_LEN = led_pkg::MAX_LEN_DEF
) (
  input logic     clk,
  input logic     rst,
  led_req_if.sink   req,
  led_rsp_if.source rsp
);
  import led_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  logic [LEN_W-1:0]  ref_len;
  logic [LEN_W-1:0]  cand_len;
  logic              ref_over;
  logic              overflow_seen;
  logic              out_valid;
  logic [DIST_W-1:0] out_distance;
  logic              out_overflow;

  logic              busy;
  logic              out_free;
  logic              accept;
  logic              is_cand;
  logic              cand_full;
  logic              ref_full;
  cell_ctl_t         ctl;
  tok_t              chain [0:MAX_LEN];
  logic [DIST_W-1:0] row_val [0:MAX_LEN];

  // handshake: characters flow freely, other commands wait for the row to drain,
  // an end command also for the result register
  assign out_free  = !out_valid || rsp.ready;
  assign is_cand   = req.cmd == CMD_CAND_APPEND;
  assign req.ready = is_cand ? 1'b1
                             : (!busy && (out_free || req.cmd != CMD_CAND_END));
  assign accept    = req.valid && req.ready;
  assign cand_full = cand_len == LEN_W'(MAX_LEN);
  assign ref_full  = ref_len == LEN_W'(MAX_LEN);

  // any wave still inside the row
  always_comb begin
    busy = 1'b0;
    for (int i = 1; i <= MAX_LEN; i++) begin
      busy = busy | chain[i].valid;
    end
  end

  // broadcast control
  assign ctl = '{restart: accept && !is_cand,
                 ref_wr:  accept && req.cmd == CMD_REF_APPEND && !ref_full,
                 ref_len: DIST_W'(ref_len),
                 ref_ch:  req.ch};

  // wave entry: column zero holds the candidate length
  assign chain[0] = '{valid: accept && is_cand && !cand_full,
                      ch:    req.ch,
                      left:  DIST_W'(cand_len) + DIST_W'(1),
                      diag:  DIST_W'(cand_len)};
  assign row_val[0] = DIST_W'(cand_len);

  // cell row
  for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
    led_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .tok_in  (chain[g-1]),
      .tok_out (chain[g]),
      .dp      (row_val[g])
    );
  end

  // command head
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len       <= '0;
      cand_len      <= '0;
      ref_over      <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      case (req.cmd)
        CMD_REF_APPEND: begin
          cand_len <= '0;
          if (ref_full) begin
            ref_over      <= 1'b1;
            overflow_seen <= 1'b1;
          end else begin
            ref_len       <= ref_len + LEN_W'(1);
            overflow_seen <= ref_over;
          end
        end
        CMD_CAND_APPEND: begin
          if (cand_full) begin
            overflow_seen <= 1'b1;
          end else begin
            cand_len <= cand_len + LEN_W'(1);
          end
        end
        CMD_CAND_END: begin
          cand_len      <= '0;
          overflow_seen <= ref_over;
        end
        default: begin
          ref_len       <= '0;
          cand_len      <= '0;
          ref_over      <= 1'b0;
          overflow_seen <= 1'b0;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && req.cmd == CMD_CAND_END) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.cmd == CMD_CAND_END) begin
      out_distance <= row_val[ref_len];
      out_overflow <= overflow_seen;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.distance = out_distance;
  assign rsp.overflow = out_overflow;

endmodule
